// File: hdl/sfes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine fit error scorer package
// Shared widths, command codes, register indexes and the sine table.
// ----------------------------------------------------------------------------
package sfes_pkg;

  localparam int MaxSamples    = 8192;
  localparam int AddrW         = $clog2(MaxSamples);
  localparam int CountW        = AddrW + 1;
  localparam int SineTableBits = 10;
  localparam int TabSize       = 1 << SineTableBits;
  localparam int QuarterBits   = SineTableBits - 2;
  localparam int QuarterSize   = 1 << QuarterBits;
  localparam int EnergyW       = 48;
  localparam int ErrW          = 64;
  localparam int CfgIdxW       = 2;
  localparam int CfgDataW      = 32;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdScore  = 2'd2;

  localparam logic [CfgIdxW-1:0] RegAmplitude = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOmegaMin  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOmegaSpan = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPhaseMax  = 2'd3;

  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569300;
  localparam logic [63:0] C7 = 64'd5026990;
  localparam logic [63:0] C9 = 64'd172272;

  typedef struct packed {
    logic [15:0] amplitude;
    logic [31:0] omega_min_step;
    logic [31:0] omega_span_step;
    logic [16:0] phase_max;
  } cfg_t;

  function automatic logic [15:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    x2 = (x * x) >> 30;
    p  = C9;
    p  = C7 - ((p * x2) >> 30);
    p  = C5 - ((p * x2) >> 30);
    p  = C3 - ((p * x2) >> 30);
    p  = C1 - ((p * x2) >> 30);
    p  = (p * x) >> 30;
    p  = (p + 64'd16384) >> 15;
    if (p > 64'd32767) begin
      p = 64'd32767;
    end
    return p[15:0];
  endfunction

  function automatic logic [QuarterSize*16-1:0] build_quarter_tab();
    logic [QuarterSize*16-1:0] t;
    t = '0;
    for (int i = 0; i < QuarterSize; i++) begin
      t[i*16 +: 16] = quarter_sine(64'(i) << (30 - QuarterBits));
    end
    return t;
  endfunction

  // Quarter wave table; the peak of the quarter is kept apart.
  localparam logic [QuarterSize*16-1:0] QuarterTab  = build_quarter_tab();
  localparam logic [15:0]               QuarterPeak = quarter_sine(64'd1 << 30);

  function automatic logic signed [15:0] sine_entry(input logic [SineTableBits-1:0] i);
    logic [1:0] q;
    logic [QuarterBits:0] r;
    logic [QuarterBits:0] rr;
    logic [15:0] v;
    q  = i[SineTableBits-1 -: 2];
    r  = {1'b0, i[QuarterBits-1:0]};
    rr = q[0] ? ((QuarterBits+1)'(QuarterSize) - r) : r;
    v  = rr[QuarterBits] ? QuarterPeak : QuarterTab[rr[QuarterBits-1:0]*16 +: 16];
    return q[1] ? -$signed(v) : $signed(v);
  endfunction

endpackage

// File: hdl/sfes_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine fit error scorer divider
// Restoring divider, one quotient bit per cycle, Q16.16 saturating result.
// ----------------------------------------------------------------------------
module sfes_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sfes_pkg::ErrW-1:0]    num_i,
  input  logic [sfes_pkg::EnergyW-1:0] den_i,
  output logic                         done_o,
  output logic [31:0]                  quot_o
);

  // Numerator is err << 16 (80 bits); quotient saturates above 32 bits.
  localparam int NumW = sfes_pkg::ErrW + 16;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0]                num_q, num_d;
  logic [sfes_pkg::EnergyW:0]     rem_q, rem_d;
  logic [sfes_pkg::EnergyW-1:0]   den_q, den_d;
  logic [32:0]                    quot_q, quot_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [sfes_pkg::EnergyW:0]     trial;
  logic [sfes_pkg::EnergyW+1:0]   diff;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[sfes_pkg::EnergyW-1:0], num_q[NumW-1]};
    diff   = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      num_d  = {num_i, 16'd0};
      rem_d  = '0;
      den_d  = den_i;
      quot_d = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (!diff[sfes_pkg::EnergyW+1]) begin
        rem_d  = diff[sfes_pkg::EnergyW:0];
        quot_d = {quot_q[31:0], 1'b1} | {quot_q[32], 32'd0};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[31:0], 1'b0} | {quot_q[32], 32'd0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Bit 32 sticks once any quotient bit shifts past the 32-bit range.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q[32] ? 32'hFFFF_FFFF : quot_q[31:0];

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done longer than one cycle");
`endif

endmodule

// File: hdl/sine_fit_error_scorer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine fit error scorer
// Stores a sampled signal and scores candidate sinusoids against it.
// ----------------------------------------------------------------------------
// Clear and append commands can follow back to back. A score command passes
// through a setup state, walks the stored samples through one sample memory
// read port and one squared-error datapath at one sample per cycle, drains the
// pipeline, runs the restoring divider and hands the result to the output
// register. With zero energy the divider is skipped, as it is for an empty store.
// The input is not ready while a score is in progress. The output register
// lets the next command in while a result waits; a finished score stalls only
// while the previous result has not yet been transferred.
module sine_fit_error_scorer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: sample_value[15:0], freq_frac[31:16], phase_frac[47:32].
  input  logic [47:0] s_axis_tdata,
  // Fields from bit 0: cmd[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: score[31:0].
  output logic [31:0] m_axis_tdata,
  // Fields from bit 0: energy_zero.
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StSetup = 5'b00010,
    StWalk  = 5'b00100,
    StDiv   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  sfes_pkg::cfg_t cfg_q;

  logic signed [15:0] mem [sfes_pkg::MaxSamples];
  logic [sfes_pkg::CountW-1:0] count_q;
  logic [sfes_pkg::EnergyW-1:0] energy_q;

  logic [sfes_pkg::CountW-1:0] rd_cnt_q;
  logic [31:0] step_q, phase_q;
  logic [47:0] prod_q;
  logic [sfes_pkg::ErrW-1:0] err_q;
  logic signed [15:0] rd_q, samp2_q;
  logic signed [15:0] sine_q;
  logic [31:0] estm_q;
  logic sneg_q;
  logic [2:0] vld_q;
  logic div_start, div_done;
  logic [31:0] div_quot;
  logic [31:0] score_q;
  logic ezero_q;
  logic out_vld_q;
  logic [31:0] out_score_q;
  logic out_ezero_q;
  logic out_load;

  logic in_fire;
  logic [1:0] cmd;
  logic signed [15:0] samp;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cmd     = s_axis_tuser;
  assign samp    = s_axis_tdata[15:0];
  assign s_axis_tready = (state_q == StIdle);
  assign out_load = (state_q == StOut) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amplitude       <= 16'd45976;
      cfg_q.omega_min_step  <= 32'd30279519;
      cfg_q.omega_span_step <= 32'd3865471;
      cfg_q.phase_max       <= 17'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfes_pkg::RegAmplitude: cfg_q.amplitude       <= cfg_data_i[15:0];
        sfes_pkg::RegOmegaMin:  cfg_q.omega_min_step  <= cfg_data_i;
        sfes_pkg::RegOmegaSpan: cfg_q.omega_span_step <= cfg_data_i;
        sfes_pkg::RegPhaseMax:  cfg_q.phase_max       <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && cmd == sfes_pkg::CmdAppend && count_q < sfes_pkg::CountW'(sfes_pkg::MaxSamples)) begin
      mem[count_q[sfes_pkg::AddrW-1:0]] <= samp;
    end
    rd_q <= mem[rd_cnt_q[sfes_pkg::AddrW-1:0]];
  end

  logic walk_rd;
  logic walk_end;
  assign walk_rd  = (state_q == StWalk) && (rd_cnt_q < count_q);
  assign walk_end = (state_q == StWalk) && !walk_rd && (vld_q == 3'd0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_fire && cmd == sfes_pkg::CmdScore) state_d = StSetup;
      StSetup: state_d = StWalk;
      StWalk:  if (walk_end) state_d = (energy_q == '0) ? StOut : StDiv;
      StDiv:   if (div_done) state_d = StOut;
      StOut:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign div_start = walk_end && (energy_q != '0);

  logic signed [31:0] sq;
  logic [33:0] sqe_q;
  logic signed [16:0] est;
  logic signed [17:0] d;
  logic [16:0] dmag;
  logic [15:0] mag;
  assign sq   = samp * samp;
  assign mag  = sine_q[15] ? 16'(-sine_q) : sine_q;
  assign est  = sneg_q ? -$signed({1'b0, estm_q[30:15]}) : $signed({1'b0, estm_q[30:15]});
  assign d    = est - samp2_q;
  assign dmag = d[17] ? 17'(-d) : d[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      energy_q  <= '0;
      rd_cnt_q  <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire && cmd == sfes_pkg::CmdClear) begin
        count_q  <= '0;
        energy_q <= '0;
      end
      if (in_fire && cmd == sfes_pkg::CmdAppend && count_q < sfes_pkg::CountW'(sfes_pkg::MaxSamples)) begin
        count_q  <= count_q + 1'b1;
        energy_q <= energy_q + sfes_pkg::EnergyW'(unsigned'(sq));
      end
      if (state_q == StSetup) rd_cnt_q <= '0;
      else if (walk_rd) rd_cnt_q <= rd_cnt_q + 1'b1;
      vld_q <= {vld_q[1:0], walk_rd};
      if (out_load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  // Pipeline: read/sine lookup, amplitude multiply, error square, accumulate.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prod_q  <= s_axis_tdata[31:16] * cfg_q.omega_span_step;
      phase_q <= 32'(s_axis_tdata[47:32]) * 32'(cfg_q.phase_max);
    end
    if (state_q == StSetup) begin
      step_q <= cfg_q.omega_min_step + prod_q[47:16];
      err_q  <= '0;
    end
    if (walk_rd) phase_q <= phase_q + step_q;
    sine_q  <= sfes_pkg::sine_entry(phase_q[31 -: sfes_pkg::SineTableBits]);
    samp2_q <= rd_q;
    estm_q  <= cfg_q.amplitude * mag + 32'd16384;
    sneg_q  <= sine_q[15];
    sqe_q   <= {17'd0, dmag} * {17'd0, dmag};
    if (vld_q[2]) err_q <= err_q + sfes_pkg::ErrW'(sqe_q);
    if (div_done) score_q <= div_quot;
    if (walk_end) begin
      ezero_q <= (energy_q == '0);
      if (energy_q == '0) score_q <= 32'hFFFF_FFFF;
    end
    if (out_load) begin
      out_score_q <= score_q;
      out_ezero_q <= ezero_q;
    end
  end

  sfes_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (err_q),
    .den_i   (energy_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_score_q;
  assign m_axis_tuser  = out_ezero_q;

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sfes_pkg::CountW'(sfes_pkg::MaxSamples)) else $error("sample count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser}))
    else $error("result changed while waiting");
  a_div_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == StDiv) else $error("divider done outside divide");
`endif

endmodule
